// ----- hdl/button_debounce_joystick_repeat_top_defines.svh -----
// Assertion macros shared by the checker.
`ifndef BUTTON_DEBOUNCE_JOYSTICK_REPEAT_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_JOYSTICK_REPEAT_TOP_DEFINES_SVH

// Clocked check, off while reset is held.
`define BDJR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bdjr check failed");

// Clocked check that also holds during reset.
`define BDJR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bdjr check failed");

`endif

// ----- hdl/bdjr_pkg.sv -----
package bdjr_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 7;
  localparam int unsigned LEVEL_W         = 7;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned MS_W            = 16;
  localparam int unsigned RAW_W           = 10;
  localparam int unsigned AXIS_W          = 8;
  localparam int unsigned DIR_W           = 4;
  localparam int unsigned APB_ADDR_W      = 5;
  localparam int unsigned APB_DATA_W      = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_JOY_EN      = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd1;
  localparam logic [2:0] REG_REPEAT_HOLD = 3'd2;
  localparam logic [2:0] REG_REPEAT_RATE = 3'd3;
  localparam logic [2:0] REG_DEAD_LOW    = 3'd4;
  localparam logic [2:0] REG_DEAD_HIGH   = 3'd5;

  localparam logic [MS_W-1:0]   DEBOUNCE_RST    = 16'd250;
  localparam logic [MS_W-1:0]   REPEAT_HOLD_RST = 16'd400;
  localparam logic [MS_W-1:0]   REPEAT_RATE_RST = 16'd120;
  localparam logic [AXIS_W-1:0] DEAD_LOW_RST    = 8'd100;
  localparam logic [AXIS_W-1:0] DEAD_HIGH_RST   = 8'd155;

  localparam logic [AXIS_W-1:0] AXIS_CENTER = 8'd127;
  localparam logic [AXIS_W-1:0] AXIS_MAX    = 8'd255;
  localparam logic [AXIS_W-1:0] OFFSET_MAX  = 8'd127;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_NONE = 4'd0;
  localparam logic [DIR_W-1:0] DIR_UL   = 4'd1;
  localparam logic [DIR_W-1:0] DIR_UR   = 4'd2;
  localparam logic [DIR_W-1:0] DIR_DL   = 4'd3;
  localparam logic [DIR_W-1:0] DIR_DR   = 4'd4;
  localparam logic [DIR_W-1:0] DIR_L    = 4'd5;
  localparam logic [DIR_W-1:0] DIR_R    = 4'd6;
  localparam logic [DIR_W-1:0] DIR_U    = 4'd7;
  localparam logic [DIR_W-1:0] DIR_D    = 4'd8;

  typedef struct packed {
    logic              joy_en;
    logic [MS_W-1:0]   debounce_ms;
    logic [MS_W-1:0]   repeat_hold_ms;
    logic [MS_W-1:0]   repeat_rate_ms;
    logic [AXIS_W-1:0] dead_low;
    logic [AXIS_W-1:0] dead_high;
  } cfg_t;

  typedef struct packed {
    logic [DIR_W-1:0]         fired;
    logic [DIR_W-1:0]         dir;
    logic signed [AXIS_W-1:0] off_x;
    logic signed [AXIS_W-1:0] off_y;
    logic                     moved;
  } stick_res_t;

endpackage

// ----- hdl/bdjr_debounce.sv -----
module bdjr_debounce #(
  parameter int unsigned NumButtons = bdjr_pkg::NUM_BUTTONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           joy_en_i,
  input  logic [bdjr_pkg::MS_W-1:0]      debounce_ms_i,
  input  logic [bdjr_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [bdjr_pkg::LEVEL_W-1:0]   levels_i,
  output logic [bdjr_pkg::LEVEL_W-1:0]   events_o
);
  import bdjr_pkg::*;

  logic [TIME_W-1:0] stamp_q [NumButtons];
  logic [TIME_W-1:0] stamp_d [NumButtons];
  logic [NumButtons-1:0] poll;
  logic [NumButtons-1:0] hit;

  for (genvar b = 0; b < NumButtons; b++) begin : g_btn
    logic level;
    logic [TIME_W-1:0] prev;
    logic [TIME_W-1:0] age;

    // Buttons without an input pin read as pressed
    if (b < LEVEL_W) begin : g_pin
      assign level = levels_i[b];
    end else begin : g_nopin
      assign level = 1'b0;
    end

    // The last button is the stick button, polled only with the stick on
    if (b == NumButtons - 1) begin : g_joy
      assign poll[b] = joy_en_i;
    end else begin : g_plain
      assign poll[b] = 1'b1;
    end

    assign prev = stamp_q[b];
    assign age  = now_ms_i - prev;

    always_comb begin
      if (!level) begin
        stamp_d[b] = (prev == '0) ? now_ms_i : prev;
      end else if (prev != '0 && age < {{(TIME_W-MS_W){1'b0}}, debounce_ms_i}) begin
        stamp_d[b] = prev;
      end else begin
        stamp_d[b] = '0;
      end
    end

    assign hit[b] = poll[b] && (prev == '0) && (stamp_d[b] != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stamp_q[b] <= '0;
      end else if (step_i && poll[b]) begin
        stamp_q[b] <= stamp_d[b];
      end
    end
  end

  for (genvar j = 0; j < LEVEL_W; j++) begin : g_evt
    if (j < NumButtons) begin : g_has
      assign events_o[j] = hit[j];
    end else begin : g_none
      assign events_o[j] = 1'b0;
    end
  end

endmodule

// ----- hdl/bdjr_stick.sv -----
module bdjr_stick (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  bdjr_pkg::cfg_t                cfg_i,
  input  logic [bdjr_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [bdjr_pkg::RAW_W-1:0]    x_raw_i,
  input  logic [bdjr_pkg::RAW_W-1:0]    y_raw_i,
  output bdjr_pkg::stick_res_t          res_o
);
  import bdjr_pkg::*;

  logic [DIR_W-1:0]  held_dir_q, held_dir_d;
  logic [TIME_W-1:0] rep_start_q, rep_start_d;
  logic [MS_W-1:0]   rep_wait_q, rep_wait_d;

  logic [AXIS_W-1:0] x, y;
  logic xl, xh, yl, yh;
  logic [DIR_W-1:0]  dir;
  logic [DIR_W-1:0]  fired;
  logic [TIME_W-1:0] since;

  function automatic logic [AXIS_W-1:0] offset_of(input logic [AXIS_W-1:0] v);
    // Only the top code overshoots +127; nothing reaches the low clamp
    return (v == AXIS_MAX) ? OFFSET_MAX : AXIS_W'(v - AXIS_CENTER);
  endfunction

  assign x  = x_raw_i[RAW_W-1 -: AXIS_W];
  assign y  = y_raw_i[RAW_W-1 -: AXIS_W];
  assign xl = x < cfg_i.dead_low;
  assign xh = x > cfg_i.dead_high;
  assign yl = y < cfg_i.dead_low;
  assign yh = y > cfg_i.dead_high;

  // First match wins, so inverted limits still give one code
  always_comb begin
    if (xl && yl)      dir = DIR_UL;
    else if (xh && yl) dir = DIR_UR;
    else if (xl && yh) dir = DIR_DL;
    else if (xh && yh) dir = DIR_DR;
    else if (xl)       dir = DIR_L;
    else if (xh)       dir = DIR_R;
    else if (yl)       dir = DIR_U;
    else if (yh)       dir = DIR_D;
    else               dir = DIR_NONE;
  end

  assign since = now_ms_i - rep_start_q;

  always_comb begin
    held_dir_d  = held_dir_q;
    rep_start_d = rep_start_q;
    rep_wait_d  = rep_wait_q;
    fired       = DIR_NONE;
    if (dir != held_dir_q) begin
      held_dir_d  = dir;
      rep_start_d = now_ms_i;
      rep_wait_d  = cfg_i.repeat_hold_ms;
      fired       = dir;
    end else if (dir != DIR_NONE &&
                 since >= {{(TIME_W-MS_W){1'b0}}, rep_wait_q}) begin
      rep_start_d = now_ms_i;
      rep_wait_d  = cfg_i.repeat_rate_ms;
      fired       = dir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_dir_q  <= DIR_NONE;
      rep_start_q <= '0;
      rep_wait_q  <= '0;
    end else if (step_i && cfg_i.joy_en) begin
      held_dir_q  <= held_dir_d;
      rep_start_q <= rep_start_d;
      rep_wait_q  <= rep_wait_d;
    end
  end

  always_comb begin
    if (cfg_i.joy_en) begin
      res_o.fired = fired;
      res_o.dir   = dir;
      res_o.off_x = offset_of(x);
      res_o.off_y = offset_of(y);
      res_o.moved = (dir != DIR_NONE);
    end else begin
      res_o = '0;
    end
  end

endmodule

// ----- hdl/button_debounce_joystick_repeat_top.sv -----
// Button debouncer with joystick auto-repeat.
//
// Input channel (in_valid_i / in_ready_o): one request per panel poll with
// a millisecond time, seven active-low button levels and two 10-bit stick
// samples. Output channel (out_valid_o / out_ready_i): exactly one result
// per request, in order: press events, fired and current direction, axis
// offsets, stick-moved and notify flags.
// Path: an accepted request moves from the input register into the result
// register once that is free or drains. Throughput: one request per cycle
// while results are taken, set by the single pass of compare/subtract logic
// between the two registers; it also updates stamps and the repeat timer.
// Stall: while out_ready_i is low the result holds; the input register
// still takes one more request, then in_ready_o drops until the result
// is taken.
// Reset (rst_ni low, asynchronous): both pipeline stages empty, all press
// stamps cleared (released), held direction and repeat timer cleared, and
// the APB registers back to their defaults.
// Configuration: APB registers at 4*index; write only while no request is
// in flight.
module button_debounce_joystick_repeat_top #(
  parameter int unsigned NumButtons = bdjr_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // APB configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bdjr_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [bdjr_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [bdjr_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  // Poll request channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bdjr_pkg::TIME_W-1:0]           now_ms_i,
  input  logic [bdjr_pkg::LEVEL_W-1:0]          button_levels_i,
  input  logic [bdjr_pkg::RAW_W-1:0]            stick_x_raw_i,
  input  logic [bdjr_pkg::RAW_W-1:0]            stick_y_raw_i,
  // Result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [bdjr_pkg::LEVEL_W-1:0]          press_events_o,
  output logic [bdjr_pkg::DIR_W-1:0]            direction_event_o,
  output logic [bdjr_pkg::DIR_W-1:0]            direction_now_o,
  output logic signed [bdjr_pkg::AXIS_W-1:0]    offset_x_o,
  output logic signed [bdjr_pkg::AXIS_W-1:0]    offset_y_o,
  output logic                                  stick_moved_o,
  output logic                                  notify_o
);
  import bdjr_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.joy_en         <= 1'b0;
      cfg_q.debounce_ms    <= DEBOUNCE_RST;
      cfg_q.repeat_hold_ms <= REPEAT_HOLD_RST;
      cfg_q.repeat_rate_ms <= REPEAT_RATE_RST;
      cfg_q.dead_low       <= DEAD_LOW_RST;
      cfg_q.dead_high      <= DEAD_HIGH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_JOY_EN:      cfg_q.joy_en         <= pwdata[0];
        REG_DEBOUNCE:    cfg_q.debounce_ms    <= pwdata[MS_W-1:0];
        REG_REPEAT_HOLD: cfg_q.repeat_hold_ms <= pwdata[MS_W-1:0];
        REG_REPEAT_RATE: cfg_q.repeat_rate_ms <= pwdata[MS_W-1:0];
        REG_DEAD_LOW:    cfg_q.dead_low       <= pwdata[AXIS_W-1:0];
        REG_DEAD_HIGH:   cfg_q.dead_high      <= pwdata[AXIS_W-1:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_JOY_EN:      prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.joy_en};
      REG_DEBOUNCE:    prdata = {{(APB_DATA_W-MS_W){1'b0}}, cfg_q.debounce_ms};
      REG_REPEAT_HOLD: prdata = {{(APB_DATA_W-MS_W){1'b0}}, cfg_q.repeat_hold_ms};
      REG_REPEAT_RATE: prdata = {{(APB_DATA_W-MS_W){1'b0}}, cfg_q.repeat_rate_ms};
      REG_DEAD_LOW:    prdata = {{(APB_DATA_W-AXIS_W){1'b0}}, cfg_q.dead_low};
      REG_DEAD_HIGH:   prdata = {{(APB_DATA_W-AXIS_W){1'b0}}, cfg_q.dead_high};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                 s1_valid_q;
  logic                 s1_adv;
  logic [TIME_W-1:0]    now_q;
  logic [LEVEL_W-1:0]   levels_q;
  logic [RAW_W-1:0]     x_raw_q;
  logic [RAW_W-1:0]     y_raw_q;
  logic                 in_fire;

  // Advance the held request whenever the result register is free or drains
  assign s1_adv     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q    <= now_ms_i;
      levels_q <= button_levels_i;
      x_raw_q  <= stick_x_raw_i;
      y_raw_q  <= stick_y_raw_i;
    end
  end

  // ---------------------------------------------------------------------
  // Per-poll logic: button stamps and stick classification / repeat.
  // Both update their state on the same edge that loads the result.
  // ---------------------------------------------------------------------
  logic [LEVEL_W-1:0] events;
  stick_res_t         stick;

  bdjr_debounce #(
    .NumButtons (NumButtons)
  ) u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_adv),
    .joy_en_i      (cfg_q.joy_en),
    .debounce_ms_i (cfg_q.debounce_ms),
    .now_ms_i      (now_q),
    .levels_i      (levels_q),
    .events_o      (events)
  );

  bdjr_stick u_stick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .cfg_i    (cfg_q),
    .now_ms_i (now_q),
    .x_raw_i  (x_raw_q),
    .y_raw_i  (y_raw_q),
    .res_o    (stick)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      press_events_o    <= events;
      direction_event_o <= stick.fired;
      direction_now_o   <= stick.dir;
      offset_x_o        <= stick.off_x;
      offset_y_o        <= stick.off_y;
      stick_moved_o     <= stick.moved;
      notify_o          <= (events != '0) || (stick.fired != DIR_NONE) || stick.moved;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/bdjr_checker.sv -----
`include "button_debounce_joystick_repeat_top_defines.svh"

module bdjr_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [bdjr_pkg::LEVEL_W-1:0]         press_events_o,
  input logic [bdjr_pkg::DIR_W-1:0]           direction_event_o,
  input logic [bdjr_pkg::DIR_W-1:0]           direction_now_o,
  input logic                                 stick_moved_o,
  input logic                                 notify_o
);
  import bdjr_pkg::*;

  // No result may be offered while reset is held
  `BDJR_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_valid_o)

  // A stalled result stays offered
  `BDJR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // A fired direction is always the current one
  `BDJR_ASSERT(a_fire_dir, clk_i, rst_ni,
    out_valid_o |-> (direction_event_o == DIR_NONE) || (direction_event_o == direction_now_o))

  // Moved flag follows the classified direction
  `BDJR_ASSERT(a_moved, clk_i, rst_ni,
    out_valid_o |-> (stick_moved_o == (direction_now_o != DIR_NONE)))

  // Notify summarizes every event source
  `BDJR_ASSERT(a_notify, clk_i, rst_ni,
    out_valid_o |-> (notify_o == ((press_events_o != '0) ||
      (direction_event_o != DIR_NONE) || stick_moved_o)))

endmodule

bind button_debounce_joystick_repeat_top bdjr_checker u_bdjr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .press_events_o    (press_events_o),
  .direction_event_o (direction_event_o),
  .direction_now_o   (direction_now_o),
  .stick_moved_o     (stick_moved_o),
  .notify_o          (notify_o)
);
